// ===== src/dpgr_pkg.sv =====
// Shared constants, codes and helper functions of the displaced point grid.
package dpgr_pkg;

    localparam int GRID_SIDE     = 32;
    localparam int POS_FRAC_BITS = 4;
    localparam int NPTS          = GRID_SIDE * GRID_SIDE;
    localparam int COORD_W       = $clog2(GRID_SIDE);
    localparam int IDX_W         = $clog2(NPTS);
    localparam int HOME_W        = 16 + COORD_W;
    localparam int VD_SH         = 8 + 2 * POS_FRAC_BITS;
    localparam int STEP_SH       = 24 - POS_FRAC_BITS;
    localparam int SQ_W          = 50;
    localparam int SQ_TOP        = 48;
    localparam int NUM_W         = 47;
    localparam int Q_W           = 21;
    localparam int DCNT_W        = $clog2(Q_W);
    localparam int WORD_W        = 33;

    localparam logic [1:0] REQ_PUSH = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;
    localparam logic [1:0] REQ_NONE = 2'd3;

    localparam logic [1:0] CFG_CELL_W    = 2'd0;
    localparam logic [1:0] CFG_CELL_H    = 2'd1;
    localparam logic [1:0] CFG_MIN_SPEED = 2'd2;
    localparam logic [1:0] CFG_STEEPNESS = 2'd3;

    localparam logic [14:0] RST_CELL_W    = 15'd640;
    localparam logic [14:0] RST_CELL_H    = 15'd480;
    localparam logic [15:0] RST_MIN_SPEED = 16'd256;
    localparam logic [15:0] RST_STEEPNESS = 16'd16;

    typedef logic signed [15:0] t_pos;

    function automatic t_pos sat16(input logic signed [22:0] v);
        t_pos res;
        if (v > 23'sd32767) begin
            res = 16'sh7fff;
        end else if (v < -23'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = t_pos'(v[15:0]);
        end
        return res;
    endfunction

    function automatic t_pos home_coord(input logic [14:0] cell_sz,
                                        input logic [COORD_W-1:0] k);
        logic [HOME_W-1:0] v;
        v = HOME_W'(cell_sz) * HOME_W'(k) + HOME_W'(cell_sz >> 1);
        return (v > HOME_W'(32767)) ? 16'sh7fff : t_pos'(v[15:0]);
    endfunction

endpackage

// ===== src/displaced_point_grid_relax_top.sv =====
// Point grid relaxation engine: one state memory, a per-point sequencer and shared sqrt/divider.
// Read request: the accepted request passes through S_RD and S_EVAL to S_DONE, which registers the result.
// Push and tick sweep all points through the memory one at a time. A skipped point goes
// straight to the next; a moved point that is neither snapped nor at zero distance runs
// through the one-bit-per-cycle square root (25 steps) and divider (21 steps per axis).
// Reset starts a pass over all points that clears every mark in the memory; no transaction
// is taken until it ends. Configuration registers return to their defaults at once.
module displaced_point_grid_relax_top
    import dpgr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_req_type,
    input  logic signed [15:0] i_object_x,
    input  logic signed [15:0] i_object_y,
    input  logic [14:0]        i_object_radius,
    input  logic [15:0]        i_delta_time,
    input  logic [4:0]         i_point_row,
    input  logic [4:0]         i_point_col,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_point_x,
    output logic signed [15:0] o_point_y,
    output logic               o_point_displaced
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_RD, S_EVAL, S_SQX, S_SQY, S_DEC, S_VD, S_STEP1, S_STEP2,
        S_SNAP, S_SNAP2, S_SQRT, S_NUM, S_DIV, S_AXIS, S_WB, S_NEXT, S_DONE
    } t_state;

    localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(NPTS - 1);
    localparam logic [COORD_W-1:0] LAST_COL = COORD_W'(GRID_SIDE - 1);

    t_state r_state;

    logic [14:0] r_cell_w, r_cell_h;
    logic [15:0] r_min_spd, r_steep;

    logic [WORD_W-1:0] mem [NPTS];
    logic [WORD_W-1:0] r_rdata;
    logic              mem_we;
    logic [WORD_W-1:0] mem_wdata;

    logic [IDX_W-1:0]   r_idx;
    logic [COORD_W-1:0] r_row, r_col;
    logic               r_oob;
    logic [1:0]         r_req;
    t_pos               r_cx, r_cy, r_px, r_py;
    logic [14:0]        r_rad;
    logic [29:0]        r_r2;
    logic [15:0]        r_dt;
    logic signed [16:0] r_dx, r_dy;
    logic               r_inbox, r_flag;
    logic [33:0]        r_d2;
    logic [40:0]        r_speed;
    logic [56:0]        r_sp1;
    logic               r_step_big;
    logic [19:0]        r_step;
    logic [39:0]        r_ss;
    logic [SQ_W-1:0]    r_sq_v, r_sq_r, r_sq_bit;
    logic [NUM_W-1:0]   r_rem, r_dsh;
    logic [Q_W-1:0]     r_q;
    logic [DCNT_W-1:0]  r_dcnt;
    logic               r_axis;
    t_pos               r_newx;
    logic               r_w_flag;
    t_pos               r_w_x, r_w_y;
    t_pos               r_res_x, r_res_y;
    logic               r_res_d;

    t_pos               hx, hy, rd_x, rd_y, cur_x, cur_y, base, newc;
    logic               rd_flag, inbox, sq_ge, div_ge, sgn, is_push;
    logic signed [16:0] dx, dy;
    logic signed [17:0] rad_s, dx18, dy18;
    logic signed [33:0] sqx, sqy;
    logic [SQ_W-1:0]    sq_try;
    logic [16:0]        ua;
    logic [27:0]        m;
    logic [24:0]        sq_root;
    logic [NUM_W-1:0]   num;
    logic [Q_W-1:0]     qc;
    logic signed [22:0] off;
    logic [63:0]        vd64, spd64, sp60, step64;

    assign o_in_ready = (r_state == S_IDLE);
    assign mem_we     = (r_state == S_CLEAR) || (r_state == S_WB);
    assign mem_wdata  = (r_state == S_CLEAR) ? '0 : {r_w_flag, r_w_x, r_w_y};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_idx] <= mem_wdata;
        end
        r_rdata <= mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_w  <= RST_CELL_W;
            r_cell_h  <= RST_CELL_H;
            r_min_spd <= RST_MIN_SPEED;
            r_steep   <= RST_STEEPNESS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CELL_W:    r_cell_w  <= i_cfg_data[14:0];
                CFG_CELL_H:    r_cell_h  <= i_cfg_data[14:0];
                CFG_MIN_SPEED: r_min_spd <= i_cfg_data;
                CFG_STEEPNESS: r_steep   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        is_push = (r_req == REQ_PUSH);
        hx      = home_coord(r_cell_w, r_col);
        hy      = home_coord(r_cell_h, r_row);
        rd_flag = r_rdata[32];
        rd_x    = t_pos'(r_rdata[31:16]);
        rd_y    = t_pos'(r_rdata[15:0]);
        cur_x   = rd_flag ? rd_x : hx;
        cur_y   = rd_flag ? rd_y : hy;
        if (r_req == REQ_TICK) begin
            dx = {hx[15], hx} - {rd_x[15], rd_x};
            dy = {hy[15], hy} - {rd_y[15], rd_y};
        end else begin
            dx = {cur_x[15], cur_x} - {r_cx[15], r_cx};
            dy = {cur_y[15], cur_y} - {r_cy[15], r_cy};
        end
        rad_s = signed'({3'b000, r_rad});
        dx18  = {dx[16], dx};
        dy18  = {dy[16], dy};
        inbox = (dx18 > -rad_s) && (dx18 < rad_s) && (dy18 > -rad_s) && (dy18 < rad_s);
        sqx   = r_dx * r_dx;
        sqy   = r_dy * r_dy;

        vd64  = (64'(r_steep) * 64'(r_d2)) >> VD_SH;
        spd64 = (vd64 > 64'(r_min_spd)) ? vd64 : 64'(r_min_spd);
        if (spd64 > (64'd1 << 40)) begin
            spd64 = 64'd1 << 40;
        end
        sp60   = (64'(r_sp1) << 6) - (64'(r_sp1) << 2);
        step64 = sp60 >> STEP_SH;

        sq_try  = r_sq_r + r_sq_bit;
        sq_ge   = (r_sq_v >= sq_try);
        sq_root = r_sq_r[24:0];

        if (r_axis) begin
            ua  = r_dy[16] ? 17'(-r_dy) : 17'(r_dy);
            sgn = r_dy[16];
        end else begin
            ua  = r_dx[16] ? 17'(-r_dx) : 17'(r_dx);
            sgn = r_dx[16];
        end
        m      = is_push ? {5'b00000, r_rad, 8'h00} : {r_step, 8'h00};
        num    = NUM_W'({45'(ua) * 45'(m), 1'b0}) + NUM_W'(sq_root);
        div_ge = (r_rem >= r_dsh);

        qc = (is_push && (r_q > Q_W'(r_rad))) ? Q_W'(r_rad) : r_q;
        off = sgn ? -signed'(23'(qc)) : signed'(23'(qc));
        if (is_push) begin
            base = r_axis ? r_cy : r_cx;
        end else begin
            base = r_axis ? r_py : r_px;
        end
        newc = sat16({{7{base[15]}}, base} + off);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready && (r_state != S_DONE)) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req   <= i_req_type;
                        r_cx    <= i_object_x;
                        r_cy    <= i_object_y;
                        r_rad   <= i_object_radius;
                        r_r2    <= 30'(i_object_radius) * 30'(i_object_radius);
                        r_dt    <= i_delta_time;
                        r_res_x <= '0;
                        r_res_y <= '0;
                        r_res_d <= 1'b0;
                        case (i_req_type)
                            REQ_PUSH, REQ_TICK: begin
                                r_idx   <= '0;
                                r_row   <= '0;
                                r_col   <= '0;
                                r_state <= S_RD;
                            end
                            REQ_READ: begin
                                r_idx   <= IDX_W'(int'(i_point_row) * GRID_SIDE
                                                  + int'(i_point_col));
                                r_row   <= COORD_W'(i_point_row);
                                r_col   <= COORD_W'(i_point_col);
                                r_oob   <= (int'(i_point_row) >= GRID_SIDE)
                                        || (int'(i_point_col) >= GRID_SIDE);
                                r_state <= S_RD;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_RD: r_state <= S_EVAL;
                S_EVAL: begin
                    r_dx    <= dx;
                    r_dy    <= dy;
                    r_inbox <= inbox;
                    r_flag  <= rd_flag;
                    r_px    <= rd_x;
                    r_py    <= rd_y;
                    if (r_req == REQ_READ) begin
                        if (!r_oob) begin
                            r_res_x <= cur_x;
                            r_res_y <= cur_y;
                            r_res_d <= rd_flag;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_SQX;
                    end
                end
                S_SQX: begin
                    r_d2    <= unsigned'(sqx);
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_d2    <= r_d2 + unsigned'(sqy);
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    if (is_push) begin
                        if (!r_inbox || (r_d2 > 34'(r_r2))) begin
                            r_state <= S_NEXT;
                        end else if (r_d2 == '0) begin
                            r_w_flag <= 1'b1;
                            r_w_x    <= sat16({{7{r_cx[15]}}, r_cx} + 23'(r_rad));
                            r_w_y    <= r_cy;
                            r_state  <= S_WB;
                        end else begin
                            r_sq_v   <= {r_d2, 16'h0000};
                            r_sq_r   <= '0;
                            r_sq_bit <= SQ_W'(1) << SQ_TOP;
                            r_state  <= S_SQRT;
                        end
                    end else if (!r_flag) begin
                        r_state <= S_NEXT;
                    end else if (r_d2 == '0) begin
                        r_w_flag <= 1'b0;
                        r_w_x    <= r_px;
                        r_w_y    <= r_py;
                        r_state  <= S_WB;
                    end else begin
                        r_state <= S_VD;
                    end
                end
                S_VD: begin
                    r_speed <= spd64[40:0];
                    r_state <= S_STEP1;
                end
                S_STEP1: begin
                    r_sp1   <= 57'(r_speed) * 57'(r_dt);
                    r_state <= S_STEP2;
                end
                S_STEP2: begin
                    r_step_big <= |step64[63:20];
                    r_step     <= step64[19:0];
                    r_state    <= S_SNAP;
                end
                S_SNAP: begin
                    if (r_step_big) begin
                        r_w_flag <= 1'b0;
                        r_w_x    <= r_px;
                        r_w_y    <= r_py;
                        r_state  <= S_WB;
                    end else begin
                        r_ss    <= 40'(r_step) * 40'(r_step);
                        r_state <= S_SNAP2;
                    end
                end
                S_SNAP2: begin
                    if (r_ss > 40'(r_d2)) begin
                        r_w_flag <= 1'b0;
                        r_w_x    <= r_px;
                        r_w_y    <= r_py;
                        r_state  <= S_WB;
                    end else begin
                        r_sq_v   <= {r_d2, 16'h0000};
                        r_sq_r   <= '0;
                        r_sq_bit <= SQ_W'(1) << SQ_TOP;
                        r_state  <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_sq_bit == '0) begin
                        r_axis  <= 1'b0;
                        r_state <= S_NUM;
                    end else begin
                        if (sq_ge) begin
                            r_sq_v <= r_sq_v - sq_try;
                            r_sq_r <= (r_sq_r >> 1) + r_sq_bit;
                        end else begin
                            r_sq_r <= r_sq_r >> 1;
                        end
                        r_sq_bit <= r_sq_bit >> 2;
                    end
                end
                S_NUM: begin
                    r_rem   <= num;
                    r_dsh   <= NUM_W'({sq_root, 1'b0}) << (Q_W - 1);
                    r_q     <= '0;
                    r_dcnt  <= DCNT_W'(Q_W - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_ge) begin
                        r_rem <= r_rem - r_dsh;
                    end
                    r_q   <= {r_q[Q_W-2:0], div_ge};
                    r_dsh <= r_dsh >> 1;
                    if (r_dcnt == '0) begin
                        r_state <= S_AXIS;
                    end else begin
                        r_dcnt <= r_dcnt - 1'b1;
                    end
                end
                S_AXIS: begin
                    if (!r_axis) begin
                        r_newx  <= newc;
                        r_axis  <= 1'b1;
                        r_state <= S_NUM;
                    end else begin
                        r_w_flag <= 1'b1;
                        r_w_x    <= r_newx;
                        r_w_y    <= newc;
                        r_state  <= S_WB;
                    end
                end
                S_WB: r_state <= S_NEXT;
                S_NEXT: begin
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        if (r_col == LAST_COL) begin
                            r_col <= '0;
                            r_row <= r_row + 1'b1;
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                        r_state <= S_RD;
                    end
                end
                S_DONE: begin
                    if (!o_out_valid || i_out_ready) begin
                        o_out_valid       <= 1'b1;
                        o_point_x         <= r_res_x;
                        o_point_y         <= r_res_y;
                        o_point_displaced <= r_res_d;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_one_per_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken twice without processing");

    a_push_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB && r_req == REQ_PUSH) |-> r_w_flag)
        else $error("push wrote a point without its mark");

    a_sqrt_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |=> (r_state == S_SQRT || r_state == S_NUM))
        else $error("square root left early");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && o_out_valid && !i_out_ready) |=> (r_state == S_DONE))
        else $error("result loaded over a pending one");

endmodule
